>>> hw/rtl/qsdt_pkg.sv
// shared types and constants of the encoder speed and distance tracker
`timescale 1ns / 1ps
package qsdt_pkg;

  // result field widths
  localparam int unsigned DELTA_W     = 17;
  localparam int unsigned DIR_W       = 2;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned RPM_W       = 21;
  localparam int unsigned DIST_W      = 38;
  localparam int unsigned AVG_W       = 29;
  localparam int unsigned OUT_FIELDS_W = DELTA_W + DIR_W + TOTAL_W + RPM_W + DIST_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 10;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // apb register map
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_INVERT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEADBAND  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RPM_STEP  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIST_STEP = 3'd4;

  // register reset values
  localparam logic       RST_INVERT    = 1'b1;
  localparam logic [7:0] RST_DEADBAND  = 8'd2;
  localparam logic [5:0] RST_RPM_STEP  = 6'd30;
  localparam logic [8:0] RST_ALPHA     = 9'd128;
  localparam logic [5:0] RST_DIST_STEP = 6'd5;

  localparam logic [8:0] ALPHA_ONE = 9'd256;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'd2;

  typedef struct packed {
    logic       invert;
    logic [7:0] deadband;
    logic [5:0] rpm_step;
    logic [8:0] alpha;
    logic [5:0] dist_step;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DEAD,
    ST_RAW,
    ST_NEW,
    ST_OLD,
    ST_DIST,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_RAW,
    MUL_NEW,
    MUL_OLD,
    MUL_DIST
  } mul_op_e;

  typedef struct packed {
    logic    load_in;
    logic    do_diff;
    logic    do_dead;
    logic    mul_en;
    mul_op_e mul_op;
    logic    add_avg;
    logic    load_out;
  } ctrl_t;

endpackage

>>> hw/rtl/qsdt_apb_regs.sv
// apb configuration registers
`timescale 1ns / 1ps
module qsdt_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qsdt_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [qsdt_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [qsdt_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output qsdt_pkg::cfg_t                    cfg_o
);
  import qsdt_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_INVERT:    cfg_d.invert    = pwdata[0];
        REG_DEADBAND:  cfg_d.deadband  = pwdata[7:0];
        REG_RPM_STEP:  cfg_d.rpm_step  = pwdata[5:0];
        REG_ALPHA:     cfg_d.alpha     = pwdata[8:0];
        REG_DIST_STEP: cfg_d.dist_step = pwdata[5:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INVERT:    prdata = {31'd0, cfg_q.invert};
      REG_DEADBAND:  prdata = {24'd0, cfg_q.deadband};
      REG_RPM_STEP:  prdata = {26'd0, cfg_q.rpm_step};
      REG_ALPHA:     prdata = {23'd0, cfg_q.alpha};
      REG_DIST_STEP: prdata = {26'd0, cfg_q.dist_step};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert    <= RST_INVERT;
      cfg_q.deadband  <= RST_DEADBAND;
      cfg_q.rpm_step  <= RST_RPM_STEP;
      cfg_q.alpha     <= RST_ALPHA;
      cfg_q.dist_step <= RST_DIST_STEP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/qsdt_mul.sv
// shared signed multiplier
`timescale 1ns / 1ps
module qsdt_mul (
  input  logic signed [qsdt_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [qsdt_pkg::MUL_B_W-1:0] b_i,
  output logic signed [qsdt_pkg::MUL_P_W-1:0] p_o
);
  import qsdt_pkg::*;

  logic signed [MUL_P_W-1:0] a_ext, b_ext;

  // sign extend both operands to full product width
  assign a_ext = {{MUL_B_W{a_i[MUL_A_W-1]}}, a_i};
  assign b_ext = {{MUL_A_W{b_i[MUL_B_W-1]}}, b_i};
  assign p_o   = a_ext * b_ext;

endmodule

>>> hw/rtl/qsdt_ctrl.sv
// sequencer for one sample through the shared multiplier
`timescale 1ns / 1ps
module qsdt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output qsdt_pkg::ctrl_t ctrl_o
);
  import qsdt_pkg::*;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_DIFF;
      ST_DIFF: state_d = ST_DEAD;
      ST_DEAD: state_d = ST_RAW;
      ST_RAW:  state_d = ST_NEW;
      ST_NEW:  state_d = ST_OLD;
      ST_OLD:  state_d = ST_DIST;
      ST_DIST: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.mul_op = MUL_RAW;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready  = 1'b1;
        ctrl_o.load_in = s_axis_tvalid;
      end
      ST_DIFF: ctrl_o.do_diff = 1'b1;
      ST_DEAD: ctrl_o.do_dead = 1'b1;
      ST_RAW: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MUL_RAW;
      end
      ST_NEW: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MUL_NEW;
      end
      ST_OLD: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_op = MUL_OLD;
      end
      ST_DIST: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_op  = MUL_DIST;
        ctrl_o.add_avg = 1'b1;
      end
      ST_DONE: ctrl_o.load_out = out_free;
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (ctrl_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;

endmodule

>>> hw/rtl/qsdt_datapath.sv
// difference, dead-band, running total, speed average and distance datapath
`timescale 1ns / 1ps
module qsdt_datapath #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qsdt_pkg::cfg_t                   cfg_i,
  input  qsdt_pkg::ctrl_t                  ctrl_i,
  input  logic [COUNTER_WIDTH-1:0]         counter_i,
  output logic [qsdt_pkg::OUT_TDATA_W-1:0] out_tdata_o
);
  import qsdt_pkg::*;

  localparam int unsigned DW = COUNTER_WIDTH + 1;
  localparam logic [63:0] MagMax = 64'd32768;

  logic [COUNTER_WIDTH-1:0] cur_q, prev_q;
  logic [COUNTER_WIDTH-1:0] diff;
  logic signed [DW-1:0]     diff_sx, d_raw, d_q, d_fin;
  logic [DW-1:0]            mag, mag_fin;
  logic [63:0]              d_ext, mag_ext;
  logic                     in_band;
  logic [15:0]              magsat, magsat_q;
  logic [DIR_W-1:0]         dir, dir_q;
  logic [DELTA_W-1:0]       delta_q;
  logic [TOTAL_W-1:0]       total_q;
  logic [8:0]               alpha_sat, alpha_inv;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p, prod_q;
  logic [29:0]              pnew_q;
  logic [30:0]              avg_sum;
  logic [AVG_W-1:0]         avg_q;

  logic [DELTA_W-1:0] o_delta_q;
  logic [DIR_W-1:0]   o_dir_q;
  logic [TOTAL_W-1:0] o_total_q;
  logic [RPM_W-1:0]   o_rpm_q;
  logic [DIST_W-1:0]  o_dist_q;

  // wrap-corrected difference, optionally negated
  assign diff    = cur_q - prev_q;
  assign diff_sx = {diff[COUNTER_WIDTH-1], diff};
  assign d_raw   = cfg_i.invert ? -diff_sx : diff_sx;

  // magnitude and dead-band
  assign mag     = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
  assign in_band = mag < DW'(cfg_i.deadband);
  assign d_fin   = in_band ? '0 : d_q;
  assign mag_fin = in_band ? '0 : mag;
  assign d_ext   = {{(64-DW){d_fin[DW-1]}}, d_fin};
  assign mag_ext = 64'(mag_fin);
  assign magsat  = (mag_ext > MagMax) ? MagMax[15:0] : mag_ext[15:0];

  always_comb begin
    if (d_fin == '0) begin
      dir = DIR_STOP;
    end else if (d_fin[DW-1]) begin
      dir = DIR_NEG;
    end else begin
      dir = DIR_POS;
    end
  end

  assign alpha_sat = (cfg_i.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_i.alpha;
  assign alpha_inv = ALPHA_ONE - alpha_sat;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (ctrl_i.mul_op)
      MUL_RAW: begin
        mul_a = {17'd0, magsat_q};
        mul_b = {4'd0, cfg_i.rpm_step};
      end
      MUL_NEW: begin
        mul_a = {12'd0, prod_q[20:0]};
        mul_b = {1'b0, alpha_sat};
      end
      MUL_OLD: begin
        mul_a = {4'd0, avg_q};
        mul_b = {1'b0, alpha_inv};
      end
      MUL_DIST: begin
        mul_a = {total_q[TOTAL_W-1], total_q};
        mul_b = {4'd0, cfg_i.dist_step};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  qsdt_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // new weighted term plus old weighted term shifted back to q.8
  assign avg_sum = 31'(pnew_q) + 31'(prod_q[37:8]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      total_q <= '0;
      avg_q   <= '0;
    end else begin
      if (ctrl_i.do_diff) prev_q  <= cur_q;
      if (ctrl_i.do_dead) total_q <= total_q + d_ext[TOTAL_W-1:0];
      if (ctrl_i.add_avg) avg_q   <= avg_sum[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) cur_q <= counter_i;
    if (ctrl_i.do_diff) d_q   <= d_raw;
    if (ctrl_i.do_dead) begin
      delta_q  <= d_ext[DELTA_W-1:0];
      dir_q    <= dir;
      magsat_q <= magsat;
    end
    if (ctrl_i.mul_en) prod_q <= mul_p;
    if (ctrl_i.mul_en && ctrl_i.mul_op == MUL_OLD) pnew_q <= prod_q[29:0];
    if (ctrl_i.load_out) begin
      o_delta_q <= delta_q;
      o_dir_q   <= dir_q;
      o_total_q <= total_q;
      o_rpm_q   <= avg_q[AVG_W-1:8];
      o_dist_q  <= prod_q[DIST_W-1:0];
    end
  end

  assign out_tdata_o = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                        o_dist_q, o_rpm_q, o_total_q, o_dir_q, o_delta_q};

endmodule

>>> hw/rtl/quadrature_speed_distance_tracker_core.sv
// top level of the quadrature encoder speed and distance tracker
`timescale 1ns / 1ps
// usage
//  - s_axis carries one word per sampling window: the raw free-running counter
//  - m_axis returns exactly one word per input word: delta, direction, running
//    total, filtered speed in centi-rpm and distance in milli-cm
//  - apb port sets inversion, dead-band, rpm step, average weight and distance
//    step; write only while no sample is in flight
//  - after the input handshake the sequencer walks difference, dead-band and four
//    passes through the one shared multiplier (raw speed, new term, old term,
//    distance), then loads the output register that drives m_axis_tvalid; a new
//    word is taken only after the last one has been loaded into that register
//  - s_axis_tready is high only while the sequencer is idle
//  - a result waits in the output register; the next sample is taken and
//    worked on meanwhile, and the sequencer holds in its last step until the
//    output register is free
//  - reset clears previous sample, total and speed average to zero, loads
//    register defaults and leaves m_axis_tvalid low
module quadrature_speed_distance_tracker_core #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // counter_value in the low COUNTER_WIDTH bits
  input  logic [((COUNTER_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // delta_counts, direction, total_counts, rpm_centi, distance_milli_cm, zero pad
  output logic [qsdt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qsdt_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [qsdt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [qsdt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import qsdt_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;

  // configuration registers
  qsdt_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // step sequencer and output valid
  qsdt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .ctrl_o        (ctrl)
  );

  // arithmetic around the shared multiplier
  qsdt_datapath #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .counter_i   (s_axis_tdata[COUNTER_WIDTH-1:0]),
    .out_tdata_o (m_axis_tdata)
  );

endmodule

>>> hw/rtl/qsdt_checker.sv
// port-level checks of the tracker, bound to the top level
`timescale 1ns / 1ps
module qsdt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [qsdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import qsdt_pkg::*;

  // one sample at a time through the sequencer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");

  // no result can appear right after a sample is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result raised too early");

  // direction code agrees with the delta it describes
  a_dir_matches_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tdata[18:17] == DIR_STOP) == (m_axis_tdata[16:0] == 17'd0)) &&
      ((m_axis_tdata[18:17] == DIR_NEG) == m_axis_tdata[16]))
    else $error("direction does not match delta");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed");

endmodule

bind quadrature_speed_distance_tracker_core qsdt_checker u_qsdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/quadrature_speed_distance_tracker_core_tb.sv
// self-checking testbench for the quadrature encoder speed and distance tracker
`timescale 1ns / 1ps
module quadrature_speed_distance_tracker_core_tb;
  import qsdt_pkg::*;

  // one output word split into its fields
  typedef struct {
    logic signed [16:0] delta;
    logic [1:0]         dir;
    logic signed [31:0] total;
    logic [20:0]        rpm;
    logic signed [37:0] distance;
  } encoder_reading_t;

  // directed script: a settings change or one counter sample
  typedef struct {
    bit               reconfigure;
    cfg_t             settings;
    logic [15:0]      sample;
    bit               typed;
    encoder_reading_t known;
  } script_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  // counter_value
  logic [15:0]              s_axis_tdata;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // delta_counts, direction, total_counts, rpm_centi, distance_milli_cm, zero pad
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  // predictor state and its copy of the registers
  cfg_t                     tracker_cfg;
  logic [15:0]              last_sample;
  logic signed [31:0]       running_total;
  logic [28:0]              speed_q8;

  encoder_reading_t         pending_readings[$];
  logic                     typed_pending;
  encoder_reading_t         typed_word;
  logic                     calm_stretch;
  logic [15:0]              last_sent;
  int                       fault_count;

  quadrature_speed_distance_tracker_core #(
    .COUNTER_WIDTH(16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // expected reading for one accepted counter sample, advances the state
  function automatic encoder_reading_t advance_tracker(input logic [15:0] sample);
    encoder_reading_t r;
    logic [15:0]      step;
    longint           moved;
    longint           mag;
    longint           weight;
    longint           raw;
    longint           mix;
    longint           travel;
    step  = sample - last_sample;
    moved = longint'($signed(step));
    if (tracker_cfg.invert) moved = -moved;
    mag = (moved < 0) ? -moved : moved;
    if (mag < longint'(tracker_cfg.deadband)) begin
      moved = 0;
      mag   = 0;
    end
    last_sample   = sample;
    running_total = running_total + moved[31:0];
    if (mag > 32768) mag = 32768;
    weight   = (tracker_cfg.alpha > ALPHA_ONE) ? 256 : longint'(tracker_cfg.alpha);
    raw      = mag * longint'(tracker_cfg.rpm_step);
    mix      = (weight * raw * 256 + (256 - weight) * longint'(speed_q8)) >>> 8;
    speed_q8 = mix[28:0];
    travel   = longint'(running_total) * longint'(tracker_cfg.dist_step);
    r.delta    = moved[16:0];
    r.dir      = (moved > 0) ? DIR_POS : ((moved < 0) ? DIR_NEG : DIR_STOP);
    r.total    = running_total;
    r.rpm      = speed_q8[28:8];
    r.distance = travel[37:0];
    return r;
  endfunction

  function automatic script_row_t settings_row(input cfg_t c);
    script_row_t row;
    row = '{reconfigure: 1'b1, settings: c, sample: '0, typed: 1'b0, known: '{default: 0}};
    return row;
  endfunction

  function automatic script_row_t sample_row(input logic [15:0] v);
    script_row_t row;
    row = '{reconfigure: 1'b0, settings: '0, sample: v, typed: 1'b0, known: '{default: 0}};
    return row;
  endfunction

  function automatic script_row_t known_row(input logic [15:0] v, input encoder_reading_t k);
    script_row_t row;
    row = '{reconfigure: 1'b0, settings: '0, sample: v, typed: 1'b1, known: k};
    return row;
  endfunction

  // offer one sample, with random gaps in front, and hold it until taken
  task automatic send_sample(input logic [15:0] value, input bit typed,
                             input encoder_reading_t known);
    while (!calm_stretch && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    typed_pending <= typed;
    typed_word    <= known;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // stop offering and wait until every reading has come back
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    typed_pending <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // apb write with junk in the unused bits, then read back
  task automatic program_register(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    int unsigned keep;
    case (idx)
      REG_INVERT:   keep = 32'h1;
      REG_DEADBAND: keep = 32'hFF;
      REG_ALPHA:    keep = 32'h1FF;
      default:      keep = 32'h3F;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~keep) | (value & keep);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_INVERT:   tracker_cfg.invert    = value[0];
      REG_DEADBAND: tracker_cfg.deadband  = value[7:0];
      REG_RPM_STEP: tracker_cfg.rpm_step  = value[5:0];
      REG_ALPHA:    tracker_cfg.alpha     = value[8:0];
      default:      tracker_cfg.dist_step = value[5:0];
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== (value & keep)) begin
      $display("%0t ns: register %0d read back expected %0d actual %0d",
               $time, idx, value & keep, prdata);
      fault_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t c);
    program_register(REG_INVERT, c.invert);
    program_register(REG_DEADBAND, c.deadband);
    program_register(REG_RPM_STEP, c.rpm_step);
    program_register(REG_ALPHA, c.alpha);
    program_register(REG_DIST_STEP, c.dist_step);
  endtask

  // sink side: random back-pressure except in the calm stretch
  always @(negedge clk_i) begin
    m_axis_tready <= calm_stretch || ($urandom_range(99) >= 12);
  end

  // prediction on input handshakes, checking on output handshakes
  always @(posedge clk_i) begin : watch
    encoder_reading_t want;
    encoder_reading_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = advance_tracker(s_axis_tdata);
        if (typed_pending) want = typed_word;
        pending_readings.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.delta    = m_axis_tdata[16:0];
        got.dir      = m_axis_tdata[18:17];
        got.total    = m_axis_tdata[50:19];
        got.rpm      = m_axis_tdata[71:51];
        got.distance = m_axis_tdata[109:72];
        if (pending_readings.size() == 0) begin
          $display("%0t ns: word on m_axis with nothing pending, delta %0d total %0d",
                   $time, got.delta, got.total);
          fault_count++;
        end else begin
          want = pending_readings.pop_front();
          if (got.delta !== want.delta) begin
            $display("%0t ns: delta_counts expected %0d actual %0d",
                     $time, want.delta, got.delta);
            fault_count++;
          end
          if (got.dir !== want.dir) begin
            $display("%0t ns: direction expected %0d actual %0d", $time, want.dir, got.dir);
            fault_count++;
          end
          if (got.total !== want.total) begin
            $display("%0t ns: total_counts expected %0d actual %0d",
                     $time, want.total, got.total);
            fault_count++;
          end
          if (got.rpm !== want.rpm) begin
            $display("%0t ns: rpm_centi expected %0d actual %0d", $time, want.rpm, got.rpm);
            fault_count++;
          end
          if (got.distance !== want.distance) begin
            $display("%0t ns: distance_milli_cm expected %0d actual %0d",
                     $time, want.distance, got.distance);
            fault_count++;
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("quadrature_speed_distance_tracker_core verification failed");
    $finish;
  end

  initial begin : stimulus
    script_row_t      script[$];
    cfg_t             phase_cfg;
    encoder_reading_t blank;
    logic [15:0]      next_value;
    int               pick;
    int               span;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    typed_pending = 1'b0;
    blank         = '{default: 0};
    typed_word    = blank;
    calm_stretch  = 1'b0;
    fault_count   = 0;
    last_sent     = '0;
    // register values and state right after reset
    tracker_cfg   = '{invert: 1'b1, deadband: 8'd2, rpm_step: 6'd30, alpha: 9'd128,
                      dist_step: 6'd5};
    last_sample   = '0;
    running_total = '0;
    speed_q8      = '0;

    // reset defaults: no motion, motion inside the dead-band, smallest kept motion
    script.push_back(known_row(16'h0000,
      '{delta: 0, dir: DIR_STOP, total: 0, rpm: 0, distance: 0}));
    script.push_back(known_row(16'h0001,
      '{delta: 0, dir: DIR_STOP, total: 0, rpm: 0, distance: 0}));
    script.push_back(known_row(16'h0003,
      '{delta: -2, dir: DIR_NEG, total: -2, rpm: 30, distance: -10}));
    // counter wrap both ways and the half-range jumps
    script.push_back(sample_row(16'hFFFF));
    script.push_back(sample_row(16'h0001));
    script.push_back(sample_row(16'h8001));
    script.push_back(sample_row(16'h0001));
    script.push_back(sample_row(16'h8000));
    script.push_back(sample_row(16'h0000));
    // no inversion, zero dead-band, full weight, largest steps
    script.push_back(settings_row('{invert: 1'b0, deadband: 8'd0, rpm_step: 6'd63,
                                    alpha: 9'd256, dist_step: 6'd63}));
    script.push_back(sample_row(16'h0000));
    script.push_back(sample_row(16'h0001));
    script.push_back(sample_row(16'h8001));
    script.push_back(sample_row(16'h0000));
    script.push_back(sample_row(16'hFFFF));
    // widest dead-band, weight above one, zero steps
    script.push_back(settings_row('{invert: 1'b1, deadband: 8'd255, rpm_step: 6'd0,
                                    alpha: 9'd511, dist_step: 6'd0}));
    script.push_back(sample_row(16'h00FD));
    script.push_back(sample_row(16'h01FC));
    // zero weight holds the average
    script.push_back(settings_row('{invert: 1'b0, deadband: 8'd1, rpm_step: 6'd1,
                                    alpha: 9'd0, dist_step: 6'd1}));
    script.push_back(sample_row(16'h2000));
    script.push_back(sample_row(16'h2000));
    script.push_back(settings_row('{invert: 1'b1, deadband: 8'd2, rpm_step: 6'd63,
                                    alpha: 9'd1, dist_step: 6'd63}));
    script.push_back(sample_row(16'h9000));
    script.push_back(sample_row(16'h1000));
    script.push_back(sample_row(16'hAAAA));
    script.push_back(sample_row(16'h5555));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].reconfigure) begin
        settle_block();
        apply_settings(script[i].settings);
      end else begin
        send_sample(script[i].sample, script[i].typed, script[i].known);
        last_sent = script[i].sample;
      end
    end

    // random phases, each under its own settings; phase 2 runs without gaps
    for (int phase = 0; phase < 6; phase++) begin
      settle_block();
      if (phase == 0) begin
        phase_cfg = '{invert: 1'b1, deadband: 8'd255, rpm_step: 6'd63, alpha: 9'd256,
                      dist_step: 6'd63};
      end else if (phase == 1) begin
        phase_cfg = '0;
      end else begin
        phase_cfg.invert    = 1'($urandom_range(1));
        phase_cfg.deadband  = ($urandom_range(99) < 70) ? 8'($urandom_range(8)) :
                                                          8'($urandom_range(255));
        phase_cfg.rpm_step  = 6'($urandom_range(63));
        phase_cfg.alpha     = ($urandom_range(99) < 85) ? 9'($urandom_range(256)) :
                                                          9'($urandom_range(511));
        phase_cfg.dist_step = 6'($urandom_range(63));
      end
      apply_settings(phase_cfg);
      calm_stretch <= (phase == 2);
      for (int k = 0; k < 225; k++) begin
        pick = $urandom_range(99);
        if (pick < 60) span = $urandom_range(400);
        else if (pick < 75) span = $urandom_range(tracker_cfg.deadband + 1);
        else span = 0;
        if (pick < 85) begin
          next_value = $urandom_range(1) ? last_sent + 16'(span) : last_sent - 16'(span);
        end else if (pick < 88) begin
          // half-range jump, the widest difference
          next_value = last_sent ^ 16'h8000;
        end else begin
          next_value = 16'($urandom);
        end
        send_sample(next_value, 1'b0, blank);
        last_sent = next_value;
      end
    end

    settle_block();
    repeat (20) @(negedge clk_i);
    if (fault_count == 0) begin
      $display("quadrature_speed_distance_tracker_core verification clean");
    end else begin
      $display("quadrature_speed_distance_tracker_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/qsdt_pkg.sv
hw/rtl/qsdt_apb_regs.sv
hw/rtl/qsdt_mul.sv
hw/rtl/qsdt_ctrl.sv
hw/rtl/qsdt_datapath.sv
hw/rtl/quadrature_speed_distance_tracker_core.sv
hw/rtl/qsdt_checker.sv
tb/quadrature_speed_distance_tracker_core_tb.sv
